### rtl/core/integer_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_macros
// Assertion macros shared by the integer to decimal ASCII converter.
// Each macro takes a label, the clock, the active-low reset, an antecedent
// and a consequent.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define ITDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itda assertion failed");

// Next-cycle implication.
`define ITDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itda assertion failed");

`endif

### rtl/core/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Widths, counts and character codes of the integer to decimal ASCII block.
// ----------------------------------------------------------------------------
package itda_pkg;

    localparam int VALUE_WIDTH = 32;
    // Decimal digits needed for VALUE_WIDTH bits: floor(W * log10(2)) + 1.
    localparam int DIGITS      = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W       = DIGITS * 4;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
    localparam int DIG_CNT_W   = $clog2(DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef logic [3:0] t_digit;

endpackage

### rtl/core/integer_to_decimal_ascii.sv
// Timing: a leading '-' is registered when the start is accepted; the final
// character is always the last step of the digit walk.
// Throughput: a new number is taken only in idle, after the busy phase of 32
// shift-and-adjust steps plus one per BCD digit slot, 10 slots. The receiver
// cannot stall, so nothing stretches this.
// Reset: synchronous, active low; clears the sequencer and the strobe only.
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a signed or unsigned binary value to decimal ASCII characters.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii
    import itda_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value_bits,
    input  logic                   i_is_signed,
    output logic [7:0]             o_ascii_char,
    output logic                   o_last_char,
    output logic                   o_strobe
);

`include "integer_to_decimal_ascii_macros.svh"

    // Sequencer codes. IDLE waits for a start beat, CONV runs the double
    // dabble conversion one input bit per cycle, EMIT walks the BCD digits
    // from the most significant end, one digit per cycle.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             r_state,    n_state;
    logic [VALUE_WIDTH-1:0] r_bin,      n_bin;
    logic [BCD_W-1:0]       r_bcd,      n_bcd;
    logic [BIT_CNT_W-1:0]   r_bit,      n_bit;
    logic [DIG_CNT_W-1:0]   r_dig_left, n_dig_left;
    logic                   r_lead,     n_lead;
    logic [7:0]             r_char,     n_char;
    logic                   r_last,     n_last;
    logic                   r_strobe,   n_strobe;

    logic                   accept;
    logic                   negative;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic [BCD_W-1:0]       bcd_adj;
    t_digit                 top_digit;

    assign accept    = start && (r_state == ST_IDLE);
    assign negative  = i_is_signed && i_value_bits[VALUE_WIDTH-1];
    // The most negative value wraps to itself, which read as unsigned is
    // exactly its magnitude.
    assign magnitude = negative ? (~i_value_bits + 1'b1) : i_value_bits;
    assign top_digit = r_bcd[BCD_W-1 -: 4];

    // Double dabble adjust: every BCD digit of five or more gets three added
    // before the shift. Digits are independent of each other.
    always_comb begin
        t_digit d;
        bcd_adj = r_bcd;
        for (int k = 0; k < DIGITS; k++) begin
            d = r_bcd[k*4 +: 4];
            bcd_adj[k*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_bin      = r_bin;
        n_bcd      = r_bcd;
        n_bit      = r_bit;
        n_dig_left = r_dig_left;
        n_lead     = r_lead;
        n_char     = r_char;
        n_last     = 1'b0;
        n_strobe   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state    = ST_CONV;
                    n_bin      = magnitude;
                    n_bcd      = '0;
                    n_bit      = BIT_CNT_W'(VALUE_WIDTH - 1);
                    n_dig_left = DIG_CNT_W'(DIGITS);
                    n_lead     = 1'b1;
                    // The sign goes out while the conversion is still running.
                    if (negative) begin
                        n_char   = CHAR_MINUS;
                        n_strobe = 1'b1;
                    end
                end
            end
            ST_CONV: begin
                n_bcd = {bcd_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
                n_bin = {r_bin[VALUE_WIDTH-2:0], 1'b0};
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                n_bcd      = {r_bcd[BCD_W-5:0], 4'd0};
                n_dig_left = r_dig_left - 1'b1;
                // Leading zeros are dropped, but the units digit always goes
                // out, so that zero still yields a single '0'.
                if (!(r_lead && (top_digit == 4'd0) && (r_dig_left != DIG_CNT_W'(1)))) begin
                    n_lead   = 1'b0;
                    n_char   = CHAR_ZERO + {4'd0, top_digit};
                    n_strobe = 1'b1;
                    n_last   = (r_dig_left == DIG_CNT_W'(1));
                end
                if (r_dig_left == DIG_CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_bit      <= n_bit;
        r_dig_left <= n_dig_left;
        r_lead     <= n_lead;
        r_char     <= n_char;
        r_last     <= n_last;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;
    assign o_strobe     = r_strobe;

    // An accepted start beat always leaves the block busy.
    `ITDA_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, accept, busy)
    // The final character coincides with the return to idle.
    `ITDA_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_strobe && o_last_char, r_state == ST_IDLE)
    // A minus sign only appears in the first conversion cycle.
    `ITDA_ASSERT_NOW(a_minus_first, i_clk, i_rst_n,
        o_strobe && (o_ascii_char == CHAR_MINUS),
        (r_state == ST_CONV) && (r_bit == BIT_CNT_W'(VALUE_WIDTH - 1)) && !o_last_char)
    // The digit walk never runs out of digit slots.
    `ITDA_ASSERT_NOW(a_emit_count, i_clk, i_rst_n, r_state == ST_EMIT, r_dig_left != '0)

endmodule
